### hw/rtl/trs_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and saturating helpers for the text run scanner.
// Used by the front, queue, back and top level files.
package trs_pkg;

  localparam int LEN_W  = 23;
  localparam int UNIT_W = 22;
  localparam int OFF_W  = 22;
  localparam int CFG_W  = 8;
  localparam int TEN_W  = 4;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DEL     = 8'h7F;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam logic [CFG_W-1:0] RST_MIN_ASCII = 8'd6;
  localparam logic [CFG_W-1:0] RST_MIN_PROSE = 8'd12;
  localparam logic [TEN_W-1:0] RST_TENTHS    = 4'd7;
  localparam logic [CFG_W-1:0] RST_MIN_UTF16 = 8'd6;

  typedef enum logic [1:0] {
    REG_MIN_ASCII = 2'd0,
    REG_MIN_PROSE = 2'd1,
    REG_TENTHS    = 2'd2,
    REG_MIN_UTF16 = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] min_ascii_run;
    logic [CFG_W-1:0] min_prose_run;
    logic [TEN_W-1:0] prose_tenths;
    logic [CFG_W-1:0] min_utf16_run;
  } cfg_t;

  typedef struct packed {
    logic              run_close;
    logic [LEN_W-1:0]  run_len;
    logic [OFF_W-1:0]  run_start;
    logic [LEN_W-1:0]  spaces;
    logic [LEN_W-1:0]  letters;
    logic              unit_close;
    logic [UNIT_W-1:0] unit_len;
    logic [OFF_W-1:0]  unit_start;
    logic              last;
  } event_t;

  typedef struct packed {
    logic [LEN_W-1:0]  text_run_count;
    logic [LEN_W-1:0]  text_byte_count;
    logic [LEN_W-1:0]  best_ascii_len;
    logic [OFF_W-1:0]  best_ascii_start;
    logic [LEN_W-1:0]  prose_run_count;
    logic [LEN_W-1:0]  best_prose_len;
    logic [OFF_W-1:0]  best_prose_start;
    logic [UNIT_W-1:0] wide_run_count;
    logic [UNIT_W-1:0] utf16_units;
    logic [UNIT_W-1:0] best_utf16_len;
    logic [OFF_W-1:0]  best_utf16_start;
  } result_t;

  function automatic logic [LEN_W-1:0] sat_add_len(input logic [LEN_W-1:0] a,
                                                   input logic [LEN_W-1:0] b);
    logic [LEN_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
  endfunction

  function automatic logic [UNIT_W-1:0] sat_add_unit(input logic [UNIT_W-1:0] a,
                                                     input logic [UNIT_W-1:0] b);
    logic [UNIT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[UNIT_W] ? {UNIT_W{1'b1}} : s[UNIT_W-1:0];
  endfunction

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= CH_SPACE && b < CH_DEL) || b == CH_NEWLINE;
  endfunction

endpackage

### hw/rtl/text_run_scanner_top.sv
`timescale 1ns / 1ps
// Top level of the text run scanner: configuration registers, front end,
// event queue and back end. Uses trs_pkg, trs_front, trs_queue, trs_back.
//
// Streams one byte per clock while the queue has room. A byte is classified
// and its open runs advanced in the cycle it is taken; a run that ends
// becomes an event word, registered in the two-word queue and then in the
// back end's qualify stage before the totals; the summary word appears on
// out_valid once the byte flagged last has passed them, and the next region
// may start on the very next cycle. Input stalls only when the summary word
// is held by out_ready and the queue behind it has filled. Configuration
// writes are taken every cycle and should be made between regions.
module text_run_scanner_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [22:0] text_run_count,
  output logic [22:0] text_byte_count,
  output logic [22:0] best_ascii_len,
  output logic [21:0] best_ascii_start,
  output logic [22:0] prose_run_count,
  output logic [22:0] best_prose_len,
  output logic [21:0] best_prose_start,
  output logic [21:0] wide_run_count,
  output logic [21:0] utf16_units,
  output logic [21:0] best_utf16_len,
  output logic [21:0] best_utf16_start
);

  trs_pkg::cfg_t    cfg;
  trs_pkg::event_t  front_ev, back_ev;
  trs_pkg::result_t result;
  logic front_valid, front_ready, back_valid, back_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_ascii_run <= trs_pkg::RST_MIN_ASCII;
      cfg.min_prose_run <= trs_pkg::RST_MIN_PROSE;
      cfg.prose_tenths  <= trs_pkg::RST_TENTHS;
      cfg.min_utf16_run <= trs_pkg::RST_MIN_UTF16;
    end else if (cfg_valid && cfg_ready) begin
      unique case (trs_pkg::cfg_reg_t'(cfg_index))
        trs_pkg::REG_MIN_ASCII: cfg.min_ascii_run <= cfg_data;
        trs_pkg::REG_MIN_PROSE: cfg.min_prose_run <= cfg_data;
        trs_pkg::REG_TENTHS:    cfg.prose_tenths  <= cfg_data[trs_pkg::TEN_W-1:0];
        trs_pkg::REG_MIN_UTF16: cfg.min_utf16_run <= cfg_data;
        default: ;
      endcase
    end
  end

  trs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .last      (last),
    .ev_valid  (front_valid),
    .ev_ready  (front_ready),
    .ev        (front_ev)
  );

  trs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_ev),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_ev)
  );

  trs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ev_valid  (back_valid),
    .ev_ready  (back_ready),
    .ev        (back_ev),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  assign text_run_count   = result.text_run_count;
  assign text_byte_count  = result.text_byte_count;
  assign best_ascii_len   = result.best_ascii_len;
  assign best_ascii_start = result.best_ascii_start;
  assign prose_run_count  = result.prose_run_count;
  assign best_prose_len   = result.best_prose_len;
  assign best_prose_start = result.best_prose_start;
  assign wide_run_count   = result.wide_run_count;
  assign utf16_units      = result.utf16_units;
  assign best_utf16_len   = result.best_utf16_len;
  assign best_utf16_start = result.best_utf16_start;

endmodule

### hw/rtl/trs_front.sv
`timescale 1ns / 1ps
// Front end: accepts bytes, classifies them and tracks the open byte and
// UTF-16 runs; emits a close event word per finished run. Uses trs_pkg.
module trs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  last,
  output logic                  ev_valid,
  input  logic                  ev_ready,
  output trs_pkg::event_t       ev
);

  logic [trs_pkg::OFF_W-1:0]  byte_offset, byte_offset_next;
  logic [trs_pkg::LEN_W-1:0]  run_len, run_len_next;
  logic [trs_pkg::OFF_W-1:0]  run_start, run_start_next;
  logic [trs_pkg::LEN_W-1:0]  spaces, spaces_next;
  logic [trs_pkg::LEN_W-1:0]  letters, letters_next;
  logic [7:0]                 held_low_byte, held_low_byte_next;
  logic [trs_pkg::UNIT_W-1:0] unit_len, unit_len_next;
  logic [trs_pkg::OFF_W-1:0]  unit_start, unit_start_next;

  logic accept, printable, is_space, is_letter, odd, pair, unit_break;
  logic [trs_pkg::LEN_W-1:0]  ext_len, ext_spaces, ext_letters;
  logic [trs_pkg::OFF_W-1:0]  ext_start, ext_unit_start;
  logic [trs_pkg::UNIT_W-1:0] ext_unit_len;

  assign in_ready = ev_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    printable  = trs_pkg::is_printable(data_byte);
    is_space   = data_byte == trs_pkg::CH_SPACE;
    is_letter  = (data_byte >= trs_pkg::CH_LOWER_A && data_byte <= trs_pkg::CH_LOWER_Z) ||
                 (data_byte >= trs_pkg::CH_UPPER_A && data_byte <= trs_pkg::CH_UPPER_Z);
    odd        = byte_offset[0];
    pair       = odd && trs_pkg::is_printable(held_low_byte) && data_byte == 8'h00;
    unit_break = odd && !pair;

    ext_len     = printable ? trs_pkg::sat_add_len(run_len, trs_pkg::LEN_W'(1)) : run_len;
    ext_start   = (printable && run_len == '0) ? byte_offset : run_start;
    ext_spaces  = (printable && is_space) ?
                  trs_pkg::sat_add_len(spaces, trs_pkg::LEN_W'(1)) : spaces;
    ext_letters = (printable && is_letter) ?
                  trs_pkg::sat_add_len(letters, trs_pkg::LEN_W'(1)) : letters;

    ext_unit_len   = pair ? trs_pkg::sat_add_unit(unit_len, trs_pkg::UNIT_W'(1)) : unit_len;
    ext_unit_start = (pair && unit_len == '0) ? {byte_offset[trs_pkg::OFF_W-1:1], 1'b0}
                                              : unit_start;

    ev.run_close  = !printable || last;
    ev.run_len    = ext_len;
    ev.run_start  = ext_start;
    ev.spaces     = ext_spaces;
    ev.letters    = ext_letters;
    ev.unit_close = unit_break || last;
    ev.unit_len   = ext_unit_len;
    ev.unit_start = ext_unit_start;
    ev.last       = last;
    ev_valid      = in_valid && (ev.run_close || ev.unit_close);
  end

  always_comb begin
    byte_offset_next   = byte_offset;
    run_len_next       = run_len;
    run_start_next     = run_start;
    spaces_next        = spaces;
    letters_next       = letters;
    held_low_byte_next = held_low_byte;
    unit_len_next      = unit_len;
    unit_start_next    = unit_start;
    if (accept) begin
      if (last) begin
        byte_offset_next   = '0;
        run_len_next       = '0;
        run_start_next     = '0;
        spaces_next        = '0;
        letters_next       = '0;
        held_low_byte_next = '0;
        unit_len_next      = '0;
        unit_start_next    = '0;
      end else begin
        byte_offset_next = byte_offset + trs_pkg::OFF_W'(1);
        run_start_next   = ext_start;
        run_len_next     = printable ? ext_len : '0;
        spaces_next      = printable ? ext_spaces : '0;
        letters_next     = printable ? ext_letters : '0;
        if (!odd) begin
          held_low_byte_next = data_byte;
        end
        unit_len_next   = unit_break ? '0 : ext_unit_len;
        unit_start_next = ext_unit_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset   <= '0;
      run_len       <= '0;
      run_start     <= '0;
      spaces        <= '0;
      letters       <= '0;
      held_low_byte <= '0;
      unit_len      <= '0;
      unit_start    <= '0;
    end else begin
      byte_offset   <= byte_offset_next;
      run_len       <= run_len_next;
      run_start     <= run_start_next;
      spaces        <= spaces_next;
      letters       <= letters_next;
      held_low_byte <= held_low_byte_next;
      unit_len      <= unit_len_next;
      unit_start    <= unit_start_next;
    end
  end

endmodule

### hw/rtl/trs_queue.sv
`timescale 1ns / 1ps
// Two-word queue of run close events between front and back.
// Uses trs_pkg for the event word type.
module trs_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  trs_pkg::event_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output trs_pkg::event_t pop_data
);

  trs_pkg::event_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count, count_next;
  logic       do_push, do_pop;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + 2'd1;
    end else if (do_pop && !do_push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

### hw/rtl/trs_back.sv
`timescale 1ns / 1ps
// Back end: qualifies closed runs (length and prose tests), then folds them
// into the totals and bests and holds the final result word. Uses trs_pkg.
module trs_back (
  input  logic            clk,
  input  logic            rst,
  input  trs_pkg::cfg_t   cfg,
  input  logic            ev_valid,
  output logic            ev_ready,
  input  trs_pkg::event_t ev,
  output logic            out_valid,
  input  logic            out_ready,
  output trs_pkg::result_t result
);

  logic                       s1_valid;
  logic                       s1_run_ok, s1_prose_ok, s1_unit_ok, s1_last;
  logic [trs_pkg::LEN_W-1:0]  s1_run_len;
  logic [trs_pkg::OFF_W-1:0]  s1_run_start;
  logic [trs_pkg::UNIT_W-1:0] s1_unit_len;
  logic [trs_pkg::OFF_W-1:0]  s1_unit_start;

  trs_pkg::result_t totals, totals_next;

  logic                       run_ok, prose_ok, unit_ok, stall, apply;
  logic [trs_pkg::LEN_W:0]    share_sum;
  logic [trs_pkg::LEN_W+4:0]  share_lhs;
  logic [trs_pkg::LEN_W+4:0]  share_rhs;

  assign stall    = s1_valid && s1_last && out_valid && !out_ready;
  assign ev_ready = !stall;
  assign apply    = s1_valid && !stall;

  always_comb begin
    run_ok    = ev.run_close && ev.run_len != '0 &&
                ev.run_len >= trs_pkg::LEN_W'(cfg.min_ascii_run);
    share_sum = {1'b0, ev.letters} + {1'b0, ev.spaces};
    share_lhs = {3'b000, share_sum, 1'b0} + {1'b0, share_sum, 3'b000};
    share_rhs = (trs_pkg::LEN_W+5)'(ev.run_len) * (trs_pkg::LEN_W+5)'(cfg.prose_tenths);
    prose_ok  = run_ok && ev.run_len >= trs_pkg::LEN_W'(cfg.min_prose_run) &&
                ev.spaces != '0 && share_lhs >= share_rhs;
    unit_ok   = ev.unit_close && ev.unit_len != '0 &&
                ev.unit_len >= trs_pkg::UNIT_W'(cfg.min_utf16_run);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ev_ready) begin
      s1_valid <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready) begin
      s1_run_ok     <= run_ok;
      s1_prose_ok   <= prose_ok;
      s1_unit_ok    <= unit_ok;
      s1_last       <= ev.last;
      s1_run_len    <= ev.run_len;
      s1_run_start  <= ev.run_start;
      s1_unit_len   <= ev.unit_len;
      s1_unit_start <= ev.unit_start;
    end
  end

  always_comb begin
    totals_next = totals;
    if (s1_run_ok) begin
      totals_next.text_run_count  =
        trs_pkg::sat_add_len(totals.text_run_count, trs_pkg::LEN_W'(1));
      totals_next.text_byte_count =
        trs_pkg::sat_add_len(totals.text_byte_count, s1_run_len);
      if (s1_run_len > totals.best_ascii_len) begin
        totals_next.best_ascii_len   = s1_run_len;
        totals_next.best_ascii_start = s1_run_start;
      end
    end
    if (s1_prose_ok) begin
      totals_next.prose_run_count =
        trs_pkg::sat_add_len(totals.prose_run_count, trs_pkg::LEN_W'(1));
      if (s1_run_len > totals.best_prose_len) begin
        totals_next.best_prose_len   = s1_run_len;
        totals_next.best_prose_start = s1_run_start;
      end
    end
    if (s1_unit_ok) begin
      totals_next.wide_run_count =
        trs_pkg::sat_add_unit(totals.wide_run_count, trs_pkg::UNIT_W'(1));
      totals_next.utf16_units = trs_pkg::sat_add_unit(totals.utf16_units, s1_unit_len);
      if (s1_unit_len > totals.best_utf16_len) begin
        totals_next.best_utf16_len   = s1_unit_len;
        totals_next.best_utf16_start = s1_unit_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      totals    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (apply) begin
        totals <= s1_last ? '0 : totals_next;
      end
      if (apply && s1_last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply && s1_last) begin
      result <= totals_next;
    end
  end

endmodule

### hw/rtl/trs_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the scanner's summary word, bound to the top level.
// Depends on text_run_scanner_top's port names only.
module trs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [22:0] text_run_count,
  input logic [22:0] text_byte_count,
  input logic [22:0] best_ascii_len,
  input logic [22:0] prose_run_count,
  input logic [22:0] best_prose_len,
  input logic [21:0] utf16_units,
  input logic [21:0] best_utf16_len
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("summary word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(text_byte_count))
    else $error("stalled summary word dropped or changed");

  a_ascii_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_ascii_len <= text_byte_count && prose_run_count <= text_run_count)
    else $error("printable totals inconsistent");

  a_prose_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_prose_len <= best_ascii_len)
    else $error("prose best longer than printable best");

  a_utf16_best: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> best_utf16_len <= utf16_units)
    else $error("UTF-16 best longer than its total");

endmodule

bind text_run_scanner_top trs_checker u_trs_checker (.*);
